[src/ids_pkg.sv]
// shared types and constants for the ignition dwell and spark timer
`timescale 1ns / 1ps

package ids_pkg;

    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DWELL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_LIMIT = 1'd1;

    // item commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CRANK = 1'b1;

    // reset values
    localparam logic [COUNT_W-1:0] MAX_DWELL_RST = 16'd2250;
    localparam logic [COUNT_W-1:0] REV_LIMIT_RST = 16'd1648;
    localparam logic [COUNT_W-1:0] COMPARE_RST   = 16'hFFFF;

    typedef struct packed {
        logic               command;
        logic [COUNT_W-1:0] spark_delay;
        logic [COUNT_W-1:0] dwell_counts;
    } in_item_t;

    typedef struct packed {
        logic               coil_drive;
        logic               ignition_enabled;
        logic [COUNT_W-1:0] period_counts;
        logic               period_fresh;
        logic [COUNT_W-1:0] dwell_start;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] max_dwell;
        logic [COUNT_W-1:0] rev_limit;
    } cfg_regs_t;

endpackage

[src/ids_stream_if.sv]
// valid/ready stream interfaces for command items and result items
`timescale 1ns / 1ps

interface ids_in_if;
    logic              valid;
    logic              ready;
    ids_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ids_out_if;
    logic               valid;
    logic               ready;
    ids_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/ids_dwell_calc.sv]
// dwell-start compare value from period, spark delay and requested dwell
`timescale 1ns / 1ps

module ids_dwell_calc
(
    input  logic [ids_pkg::COUNT_W-1:0] period,
    input  logic [ids_pkg::COUNT_W-1:0] spark_delay,
    input  logic [ids_pkg::COUNT_W-1:0] dwell_counts,
    input  logic [ids_pkg::COUNT_W-1:0] max_dwell,
    output logic [ids_pkg::COUNT_W-1:0] dwell_start
);

    logic [ids_pkg::COUNT_W-1:0] dwell_clamped;

    assign dwell_clamped = (dwell_counts > max_dwell) ? max_dwell : dwell_counts;

    // all arithmetic wraps at 16 bits
    always_comb
    begin
        if (spark_delay > max_dwell)
        begin
            dwell_start = spark_delay - max_dwell;
        end
        else
        begin
            dwell_start = period + spark_delay - dwell_clamped;
        end
    end

endmodule

[src/ids_timer_core.sv]
// timer state, compare matching and coil control for one item per cycle while step is high
`timescale 1ns / 1ps

module ids_timer_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ids_pkg::in_item_t   item,
    input  ids_pkg::cfg_regs_t  cfg,
    output ids_pkg::out_item_t  result
);

    logic [ids_pkg::COUNT_W-1:0] tick_count_reg, tick_count_next;
    logic [ids_pkg::COUNT_W-1:0] last_period_reg, last_period_next;
    logic                        spark_enable_reg, spark_enable_next;
    logic [ids_pkg::COUNT_W-1:0] dwell_compare_reg, dwell_compare_next;
    logic [ids_pkg::COUNT_W-1:0] spark_compare_reg, spark_compare_next;
    logic                        coil_state_reg, coil_state_next;

    logic [ids_pkg::COUNT_W-1:0] count_inc;
    logic [ids_pkg::COUNT_W-1:0] dwell_point;

    assign count_inc = tick_count_reg + 1'b1;

    // on a crank edge the period is the current count
    ids_dwell_calc u_dwell_calc
    (
        .period       (tick_count_reg),
        .spark_delay  (item.spark_delay),
        .dwell_counts (item.dwell_counts),
        .max_dwell    (cfg.max_dwell),
        .dwell_start  (dwell_point)
    );

    always_comb
    begin
        tick_count_next    = tick_count_reg;
        last_period_next   = last_period_reg;
        spark_enable_next  = spark_enable_reg;
        dwell_compare_next = dwell_compare_reg;
        spark_compare_next = spark_compare_reg;
        coil_state_next    = coil_state_reg;

        if (item.command == ids_pkg::CMD_CRANK)
        begin
            last_period_next   = tick_count_reg;
            tick_count_next    = '0;
            spark_enable_next  = (tick_count_reg > cfg.rev_limit);
            spark_compare_next = item.spark_delay;
            dwell_compare_next = dwell_point;
        end
        else
        begin
            tick_count_next = count_inc;
            // wrap to zero cuts ignition before the compares are checked
            if (count_inc == '0)
            begin
                spark_enable_next = 1'b0;
            end
            if (count_inc == dwell_compare_reg)
            begin
                coil_state_next = spark_enable_next;
            end
            // spark match wins over dwell match
            if (count_inc == spark_compare_reg)
            begin
                coil_state_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            last_period_reg   <= '0;
            spark_enable_reg  <= 1'b1;
            dwell_compare_reg <= ids_pkg::COMPARE_RST;
            spark_compare_reg <= ids_pkg::COMPARE_RST;
            coil_state_reg    <= 1'b0;
        end
        else if (step)
        begin
            tick_count_reg    <= tick_count_next;
            last_period_reg   <= last_period_next;
            spark_enable_reg  <= spark_enable_next;
            dwell_compare_reg <= dwell_compare_next;
            spark_compare_reg <= spark_compare_next;
            coil_state_reg    <= coil_state_next;
        end
    end

    assign result.coil_drive       = coil_state_next;
    assign result.ignition_enabled = spark_enable_next;
    assign result.period_counts    = last_period_next;
    assign result.period_fresh     = (item.command == ids_pkg::CMD_CRANK);
    assign result.dwell_start      = dwell_compare_next;

endmodule

[src/ignition_dwell_spark_timer.sv]
// top level: input register, timer core, result register and config registers
`timescale 1ns / 1ps

// Inductive ignition dwell and spark timer. Each transfer on in_item is one timer
// tick or one crank edge and yields exactly one result transfer on out_item.
// An item passes through the input register and then the result register, and
// one item is taken every cycle as long as out_item is drained; the timer state
// update is a single 16-bit add, subtract and compare pass, which sets this
// one-item-per-cycle rate. With out_item stalled, one further item is still taken
// into the input register only if that register is empty. The user must write
// max_dwell and rev_limit through cfg_we/cfg_index/cfg_data only while no item is
// in flight; the block itself does not enforce this.

module ignition_dwell_spark_timer
(
    input  logic                             clk,
    input  logic                             rst_n,
    ids_in_if.sink                           in_item,
    ids_out_if.source                        out_item,
    input  logic                             cfg_we,
    input  logic [ids_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ids_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic               in_valid_reg;
    ids_pkg::in_item_t  in_data_reg;
    logic               out_valid_reg;
    ids_pkg::out_item_t out_data_reg;
    ids_pkg::cfg_regs_t cfg_reg;
    ids_pkg::out_item_t core_result;

    logic advance;
    logic step;

    assign advance = !out_valid_reg || out_item.ready;
    assign step    = in_valid_reg && advance;

    assign in_item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_dwell <= ids_pkg::MAX_DWELL_RST;
            cfg_reg.rev_limit <= ids_pkg::REV_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ids_pkg::CFG_MAX_DWELL: cfg_reg.max_dwell <= cfg_data;
                ids_pkg::CFG_REV_LIMIT: cfg_reg.rev_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_item.ready)
        begin
            in_valid_reg <= in_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_item.valid && in_item.ready)
        begin
            in_data_reg <= in_item.data;
        end
    end

    ids_timer_core u_timer_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= core_result;
        end
    end

    assign out_item.valid = out_valid_reg;
    assign out_item.data  = out_data_reg;

endmodule

[bench/tb.sv]
// self-checking bench for the ignition dwell and spark timer
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [ids_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ids_pkg::CFG_DATA_W-1:0] cfg_data;

    ids_in_if  cmd_ch ();
    ids_out_if res_ch ();

    ignition_dwell_spark_timer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (cmd_ch),
        .out_item  (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // timer model state and its copy of the registers
    logic [ids_pkg::COUNT_W-1:0] max_dwell_q;
    logic [ids_pkg::COUNT_W-1:0] rev_limit_q;
    logic [ids_pkg::COUNT_W-1:0] timer_q;
    logic [ids_pkg::COUNT_W-1:0] period_q;
    logic [ids_pkg::COUNT_W-1:0] dwell_cmp_q;
    logic [ids_pkg::COUNT_W-1:0] spark_cmp_q;
    logic                        ign_en_q;
    logic                        coil_q;

    ids_pkg::in_item_t  crank_tick_items[$];
    ids_pkg::out_item_t timer_outputs_due[$];

    logic cmd_taken;
    int   quiet_cycles;
    int   send_idle_pct = 6;
    int   recv_idle_pct = 6;

    int items_sent;
    int crank_count;
    int charge_count;
    int results_checked;
    int mismatches;
    int settings_used;

    always #5 clk = ~clk;

    function automatic void reset_timer_model();
        max_dwell_q = ids_pkg::MAX_DWELL_RST;
        rev_limit_q = ids_pkg::REV_LIMIT_RST;
        timer_q     = '0;
        period_q    = '0;
        ign_en_q    = 1'b1;
        dwell_cmp_q = ids_pkg::COMPARE_RST;
        spark_cmp_q = ids_pkg::COMPARE_RST;
        coil_q      = 1'b0;
    endfunction

    // all arithmetic is 16 bits wide, so it wraps on its own
    function automatic logic [ids_pkg::COUNT_W-1:0] dwell_start_for(
        logic [ids_pkg::COUNT_W-1:0] period,
        logic [ids_pkg::COUNT_W-1:0] spark,
        logic [ids_pkg::COUNT_W-1:0] dwell);
        if (spark > max_dwell_q)
            return spark - max_dwell_q;
        else if (dwell > max_dwell_q)
            return period + spark - max_dwell_q;
        return period + spark - dwell;
    endfunction

    function automatic ids_pkg::out_item_t step_ignition_timer(ids_pkg::in_item_t it);
        ids_pkg::out_item_t r;
        logic               was_on;
        was_on         = coil_q;
        r.period_fresh = 1'b0;
        if (it.command == ids_pkg::CMD_CRANK)
        begin
            period_q       = timer_q;
            timer_q        = '0;
            ign_en_q       = (period_q > rev_limit_q);
            spark_cmp_q    = it.spark_delay;
            dwell_cmp_q    = dwell_start_for(period_q, it.spark_delay, it.dwell_counts);
            r.period_fresh = 1'b1;
            crank_count++;
        end
        else
        begin
            timer_q = timer_q + 1'b1;
            // overflow cuts ignition before the compares are looked at
            if (timer_q == '0)
                ign_en_q = 1'b0;
            if (timer_q == dwell_cmp_q)
                coil_q = ign_en_q;
            // spark wins over a dwell match on the same count
            if (timer_q == spark_cmp_q)
                coil_q = 1'b0;
        end
        if (coil_q && !was_on)
            charge_count++;
        r.coil_drive       = coil_q;
        r.ignition_enabled = ign_en_q;
        r.period_counts    = period_q;
        r.dwell_start      = dwell_cmp_q;
        return r;
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0d, got %0d (result %0d)",
                         $time, name, want, got, results_checked);
        end
    endtask

    task automatic check_result(ids_pkg::out_item_t got);
        ids_pkg::out_item_t want;
        if (timer_outputs_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display({"%0t: result with nothing outstanding: ",
                          "coil=%0d en=%0d period=%0d fresh=%0d dwell=%0d"},
                         $time, got.coil_drive, got.ignition_enabled, got.period_counts,
                         got.period_fresh, got.dwell_start);
            return;
        end
        want = timer_outputs_due.pop_front();
        compare_field("coil_drive", want.coil_drive, got.coil_drive);
        compare_field("ignition_enabled", want.ignition_enabled, got.ignition_enabled);
        compare_field("period_counts", want.period_counts, got.period_counts);
        compare_field("period_fresh", want.period_fresh, got.period_fresh);
        compare_field("dwell_start", want.dwell_start, got.dwell_start);
        results_checked++;
    endtask

    // driver: new values go out on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_taken)
                void'(crank_tick_items.pop_front());
            if (cmd_ch.valid && !cmd_taken)
                cmd_ch.valid <= 1'b1;
            else if (crank_tick_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_ch.valid <= 1'b1;
                cmd_ch.data  <= crank_tick_items[0];
            end
            else
                cmd_ch.valid <= 1'b0;
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: a transfer happens on the rising edge with valid and ready high
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_taken    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
            if (res_ch.valid && res_ch.ready)
                check_result(res_ch.data);
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                timer_outputs_due.push_back(step_ignition_timer(cmd_ch.data));
                items_sent++;
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, timer_outputs_due.size());
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(logic cmd, int spark, int dwell);
        ids_pkg::in_item_t it;
        it.command      = cmd;
        it.spark_delay  = spark[15:0];
        it.dwell_counts = dwell[15:0];
        crank_tick_items.push_back(it);
    endtask

    // ticks carry random junk in the unused fields
    task automatic push_ticks(int n);
        repeat (n)
            push_item(ids_pkg::CMD_TICK, $urandom, $urandom);
    endtask

    // whole engine cycles: a crank edge, then the ticks of the next period
    task automatic push_engine_cycles(int n_items, int max_period);
        int added;
        int period;
        int spark;
        int dwell;
        added = 0;
        while (added < n_items)
        begin
            period = $urandom_range(max_period, 0);
            if ($urandom_range(99) < 10)
            begin
                spark = $urandom;
                dwell = $urandom;
            end
            else
            begin
                spark = $urandom_range(period + 4, 0);
                case ($urandom_range(2, 0))
                    0: dwell = $urandom_range(int'(max_dwell_q) + 3, 0);
                    1: dwell = $urandom_range(period + 4, 0);
                    default: dwell = $urandom;
                endcase
            end
            push_item(ids_pkg::CMD_CRANK, spark, dwell);
            push_ticks(period);
            added += period + 1;
        end
    endtask

    task automatic write_reg(logic [ids_pkg::CFG_IDX_W-1:0] idx,
                             logic [ids_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == ids_pkg::CFG_MAX_DWELL)
            max_dwell_q = val;
        else
            rev_limit_q = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int max_dwell, int rev_limit);
        write_reg(ids_pkg::CFG_MAX_DWELL, max_dwell[15:0]);
        write_reg(ids_pkg::CFG_REV_LIMIT, rev_limit[15:0]);
        settings_used++;
        @(posedge clk);
    endtask

    // sender holds off until every result is back and the pipe is empty
    task automatic drain_all();
        do
            @(negedge clk);
        while (crank_tick_items.size() != 0 || cmd_ch.valid || timer_outputs_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
        reset_timer_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // register values out of reset
        push_ticks(1);
        push_item(ids_pkg::CMD_CRANK, 3000, 0);
        push_item(ids_pkg::CMD_CRANK, 100, 100);
        drain_all();

        // short periods: each dwell branch, rev limit boundary, both compares on one count
        set_config(2, 1);
        push_item(ids_pkg::CMD_CRANK, 16'hFFFF, 0);
        push_ticks(4);
        push_item(ids_pkg::CMD_CRANK, 4, 1);
        push_ticks(4);
        push_item(ids_pkg::CMD_CRANK, 1, 16'hFFFF);
        push_ticks(2);
        push_item(ids_pkg::CMD_CRANK, 1, 2);
        push_ticks(1);
        push_item(ids_pkg::CMD_CRANK, 0, 0);
        push_ticks(1);
        push_item(ids_pkg::CMD_CRANK, 2, 2);
        push_ticks(1);
        drain_all();

        set_config(20, 10);
        push_engine_cycles(390, 60);
        drain_all();

        set_config(0, 0);
        push_engine_cycles(390, 40);
        drain_all();

        // back-to-back transfers with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(6, 30);
        push_engine_cycles(390, 50);
        drain_all();
        send_idle_pct = 6;
        recv_idle_pct = 6;

        set_config($urandom_range(40, 0), $urandom_range(40, 0));
        push_engine_cycles(390, 40);
        drain_all();

        set_config(45, 5);
        push_engine_cycles(200, 70);
        drain_all();
        @(posedge clk);
        push_engine_cycles(200, 70);
        drain_all();
        repeat (5) @(posedge clk);

        $display("covered %0d items with %0d crank edges over %0d register settings",
                 items_sent, crank_count, settings_used);
        $display("checked %0d results, coil charge started %0d times, %0d mismatches",
                 results_checked, charge_count, mismatches);
        if (mismatches == 0 && timer_outputs_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
